// ===== src/pn3d_pkg.sv =====
`timescale 1ns / 1ps
package pn3d_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TBL_AW        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DW        = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_OFF_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_AMP = 3'd6;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Operation issued to the shared multiplier.
    typedef enum logic [3:0] {
        MK_NONE   = 4'd0,
        MK_COORD  = 4'd1,
        MK_FA     = 4'd2,
        MK_FB     = 4'd3,
        MK_FC     = 4'd4,
        MK_FD     = 4'd5,
        MK_CORNER = 4'd6,
        MK_YLERP  = 4'd7,
        MK_ZLERP  = 4'd8,
        MK_AMP    = 4'd9
    } t_mul_kind;

    typedef struct packed {
        logic      load;
        logic      tbl_we;
        t_mul_kind mul;
        logic [1:0] idx;
        logic      tbl_rd;
        logic [3:0] tstep;
        logic      cache_upd;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic miss;
        logic out_full;
    } t_dp_status;

endpackage

// ===== src/pn3d_ctrl.sv =====
`timescale 1ns / 1ps
module pn3d_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_op,
    output logic                 o_ready,
    input  pn3d_pkg::t_dp_status i_status,
    output pn3d_pkg::t_dp_cmd    o_cmd
);
    import pn3d_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE = 14'h0001,
        ST_CRD  = 14'h0002,
        ST_FA   = 14'h0004,
        ST_FB   = 14'h0008,
        ST_FC   = 14'h0010,
        ST_FD   = 14'h0020,
        ST_HIT  = 14'h0040,
        ST_TBL  = 14'h0080,
        ST_CRN  = 14'h0100,
        ST_YL   = 14'h0200,
        ST_ZL   = 14'h0400,
        ST_ZW   = 14'h0800,
        ST_AMP  = 14'h1000,
        ST_FIN  = 14'h2000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       accept;

    assign o_ready = (r_state == ST_IDLE) & i_rst_n;
    assign accept  = i_valid & o_ready;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.mul     = MK_NONE;
        o_cmd.idx     = r_cnt[1:0];
        o_cmd.tstep   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load   = accept & (i_op == OP_SAMPLE);
                o_cmd.tbl_we = accept & (i_op == OP_LOAD);
                n_cnt        = 4'd0;
                if (accept && i_op == OP_SAMPLE) begin
                    n_state = ST_CRD;
                end
            end
            ST_CRD, ST_FA, ST_FB, ST_FC, ST_FD: begin
                case (r_state)
                    ST_CRD:  o_cmd.mul = MK_COORD;
                    ST_FA:   o_cmd.mul = MK_FA;
                    ST_FB:   o_cmd.mul = MK_FB;
                    ST_FC:   o_cmd.mul = MK_FC;
                    default: o_cmd.mul = MK_FD;
                endcase
                if (r_cnt == 4'd2) begin
                    n_cnt = 4'd0;
                    case (r_state)
                        ST_CRD:  n_state = ST_FA;
                        ST_FA:   n_state = ST_FB;
                        ST_FB:   n_state = ST_FC;
                        ST_FC:   n_state = ST_FD;
                        default: n_state = ST_HIT;
                    endcase
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_HIT: begin
                n_cnt   = 4'd0;
                n_state = i_status.miss ? ST_TBL : ST_YL;
            end
            ST_TBL: begin
                o_cmd.tbl_rd = 1'b1;
                if (r_cnt == 4'd13) begin
                    n_cnt   = 4'd0;
                    n_state = ST_CRN;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_CRN: begin
                o_cmd.mul       = MK_CORNER;
                o_cmd.cache_upd = (r_cnt == 4'd0);
                if (r_cnt == 4'd3) begin
                    n_cnt   = 4'd0;
                    n_state = ST_YL;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_YL: begin
                // The last count is a bubble so the second row lands before use.
                o_cmd.mul = (r_cnt == 4'd2) ? MK_NONE : MK_YLERP;
                if (r_cnt == 4'd2) begin
                    n_cnt   = 4'd0;
                    n_state = ST_ZL;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_ZL: begin
                o_cmd.mul = MK_ZLERP;
                n_state   = ST_ZW;
            end
            ST_ZW: begin
                n_state = ST_AMP;
            end
            ST_AMP: begin
                o_cmd.mul = MK_AMP;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = 4'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== src/pn3d_dp.sv =====
`timescale 1ns / 1ps
module pn3d_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pn3d_pkg::t_dp_cmd                 i_cmd,
    output pn3d_pkg::t_dp_status              o_status,
    input  logic                              i_cfg_we,
    input  logic [pn3d_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pn3d_pkg::CFG_DW-1:0]       i_cfg_data,
    input  logic [7:0]                        i_table_index,
    input  logic [7:0]                        i_table_value,
    input  logic signed [23:0]                i_pos_x,
    input  logic signed [23:0]                i_pos_y,
    input  logic signed [23:0]                i_pos_z,
    input  logic                              i_column_start,
    input  logic signed [31:0]                i_acc_in,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic signed [31:0]                o_acc_out
);
    import pn3d_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int AW = (F + 4 > 25) ? F + 4 : 25;
    localparam int BW = 33;
    localparam int PW = AW + BW;
    localparam int IW = F + 5;
    localparam int GW = F + 3;
    localparam int MW = F + 4;
    localparam int SW = PW + 1;

    localparam logic signed [IW-1:0] C15    = IW'(15 * (1 << F));
    localparam logic signed [IW-1:0] C10    = IW'(10 * (1 << F));
    localparam logic signed [GW-1:0] ONE_G  = GW'(1 << F);
    localparam logic signed [SW-1:0] SAT_HI = SW'(32'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_LO = SW'(32'sh8000_0000);

    function automatic logic signed [GW-1:0] grad(
        input logic [3:0]           h,
        input logic signed [GW-1:0] x,
        input logic signed [GW-1:0] y,
        input logic signed [GW-1:0] z
    );
        logic signed [GW-1:0] a;
        logic signed [GW-1:0] b;
        a = (h < 4'd8) ? x : y;
        if (h < 4'd4) begin
            b = y;
        end else if (h inside {4'd12, 4'd14}) begin
            b = x;
        end else begin
            b = z;
        end
        if (h[0]) a = -a;
        if (h[1]) b = -b;
        return a + b;
    endfunction

    // Configuration.
    logic signed [47:0] r_off   [3];
    logic signed [31:0] r_scale [3];
    logic [31:0]        r_inv;

    // Latched sample.
    logic [23:0]        r_pos [3];
    logic               r_col;
    logic signed [31:0] r_acc;

    // Per-axis lattice values.
    logic [7:0]           r_cell  [3];
    logic [F-1:0]         r_t     [3];
    logic signed [IW-1:0] r_inner [3];
    logic [F-1:0]         r_t2    [3];
    logic [F-1:0]         r_t3    [3];
    logic [F:0]           r_fade  [3];

    // Permutation memory and hash pipeline.
    logic [7:0] mem [TABLE_ENTRIES];
    logic [7:0] r_rd;
    logic       r_rvalid;
    logic [3:0] r_rstep;
    logic [7:0] r_a, r_b, r_aa, r_ab, r_ba, r_bb;
    logic [3:0] r_h [8];
    logic [TBL_AW-1:0] rd_addr;

    // Reuse cache.
    logic [7:0]           r_ccy;
    logic                 r_cvalid;
    logic signed [MW-1:0] r_mix [4];

    // Shared multiplier.
    logic signed [AW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] p_sh;
    t_mul_kind            r_wb;
    logic [1:0]           r_widx;

    logic signed [GW-1:0] r_glo;
    logic signed [MW-1:0] r_y0, r_y1, r_val;

    logic signed [IW-1:0] six_m;
    logic signed [IW-1:0] t_ext;
    logic [3:0]           h_lo, h_hi;
    logic signed [GW-1:0] fx0, fx1, fy, fz, g_lo, g_hi;
    logic signed [MW:0]   g_diff, mix_diff, y_diff;
    logic [23:0]          c24;
    logic [F+15:0]        frac_w;
    logic signed [SW-1:0] sum;
    logic signed [31:0]   sat;
    logic                 r_ovalid;
    logic signed [31:0]   r_out;

    assign p_sh = r_prod >>> F;

    assign t_ext = IW'(r_t[i_cmd.idx]);
    assign six_m = (t_ext <<< 2) + (t_ext <<< 1) - C15;

    // Corner selection: corner i pairs hashes 2i and 2i+1, y by bit 0, z by bit 1.
    always_comb begin
        case (i_cmd.idx)
            2'd0: begin h_lo = r_h[0]; h_hi = r_h[1]; end
            2'd1: begin h_lo = r_h[2]; h_hi = r_h[3]; end
            2'd2: begin h_lo = r_h[4]; h_hi = r_h[5]; end
            default: begin h_lo = r_h[6]; h_hi = r_h[7]; end
        endcase
        fx0 = GW'(r_t[0]);
        fx1 = fx0 - ONE_G;
        fy  = i_cmd.idx[0] ? (GW'(r_t[1]) - ONE_G) : GW'(r_t[1]);
        fz  = i_cmd.idx[1] ? (GW'(r_t[2]) - ONE_G) : GW'(r_t[2]);
        g_lo = grad(h_lo, fx0, fy, fz);
        g_hi = grad(h_hi, fx1, fy, fz);
        g_diff = (MW+1)'(g_hi) - (MW+1)'(g_lo);
        if (i_cmd.idx[0]) begin
            mix_diff = (MW+1)'(r_mix[3]) - (MW+1)'(r_mix[2]);
        end else begin
            mix_diff = (MW+1)'(r_mix[1]) - (MW+1)'(r_mix[0]);
        end
        y_diff = (MW+1)'(r_y1) - (MW+1)'(r_y0);
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.mul)
            MK_COORD: begin
                op_a = AW'(r_pos[i_cmd.idx]);
                op_b = BW'(r_scale[i_cmd.idx][23:0]);
            end
            MK_FA: begin
                op_a = AW'(r_t[i_cmd.idx]);
                op_b = BW'(six_m);
            end
            MK_FB: begin
                op_a = AW'(r_t[i_cmd.idx]);
                op_b = BW'(r_t[i_cmd.idx]);
            end
            MK_FC: begin
                op_a = AW'(r_t2[i_cmd.idx]);
                op_b = BW'(r_t[i_cmd.idx]);
            end
            MK_FD: begin
                op_a = AW'(r_t3[i_cmd.idx]);
                op_b = BW'(r_inner[i_cmd.idx]);
            end
            MK_CORNER: begin
                op_a = AW'(r_fade[0]);
                op_b = BW'(g_diff);
            end
            MK_YLERP: begin
                op_a = AW'(r_fade[1]);
                op_b = BW'(mix_diff);
            end
            MK_ZLERP: begin
                op_a = AW'(r_fade[2]);
                op_b = BW'(y_diff);
            end
            MK_AMP: begin
                op_a = AW'(r_val);
                op_b = BW'(r_inv);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Only the low 24 bits of a coordinate carry the cell and the fraction.
    assign c24    = r_off[r_widx][23:0] + r_prod[23:0];
    assign frac_w = {c24[15:0], {F{1'b0}}} >> 16;

    always_comb begin
        case (i_cmd.tstep)
            4'd0:    rd_addr = r_cell[0];
            4'd1:    rd_addr = r_cell[0] + 8'd1;
            4'd2:    rd_addr = r_a;
            4'd3:    rd_addr = r_a + 8'd1;
            4'd4:    rd_addr = r_b;
            4'd5:    rd_addr = r_b + 8'd1;
            4'd6:    rd_addr = r_aa;
            4'd7:    rd_addr = r_ba;
            4'd8:    rd_addr = r_ab;
            4'd9:    rd_addr = r_bb;
            4'd10:   rd_addr = r_aa + 8'd1;
            4'd11:   rd_addr = r_ba + 8'd1;
            4'd12:   rd_addr = r_ab + 8'd1;
            4'd13:   rd_addr = r_bb + 8'd1;
            default: rd_addr = r_cell[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_we) begin
            mem[i_table_index] <= i_table_value;
        end
        if (i_cmd.tbl_rd) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rvalid) begin
            case (r_rstep) inside
                4'd0:          r_a  <= r_rd + r_cell[1];
                4'd1:          r_b  <= r_rd + r_cell[1];
                4'd2:          r_aa <= r_rd + r_cell[2];
                4'd3:          r_ab <= r_rd + r_cell[2];
                4'd4:          r_ba <= r_rd + r_cell[2];
                4'd5:          r_bb <= r_rd + r_cell[2];
                [4'd6:4'd13]:  r_h[3'(r_rstep - 4'd6)] <= r_rd[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
            r_rstep  <= 4'd0;
            r_wb     <= MK_NONE;
            r_widx   <= 2'd0;
        end else begin
            r_rvalid <= i_cmd.tbl_rd;
            r_rstep  <= i_cmd.tstep;
            r_wb     <= i_cmd.mul;
            r_widx   <= i_cmd.idx;
        end
    end

    // Multiplier, sample latch and write-back of the previous cycle's product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul != MK_NONE) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.mul == MK_CORNER) begin
            r_glo <= g_lo;
        end
        if (i_cmd.load) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_col    <= i_column_start;
            r_acc    <= i_acc_in;
        end
        case (r_wb)
            MK_COORD: begin
                r_cell[r_widx] <= c24[23:16];
                r_t[r_widx]    <= frac_w[F-1:0];
            end
            MK_FA:     r_inner[r_widx] <= IW'(p_sh) + C10;
            MK_FB:     r_t2[r_widx]    <= p_sh[F-1:0];
            MK_FC:     r_t3[r_widx]    <= p_sh[F-1:0];
            MK_FD:     r_fade[r_widx]  <= p_sh[F:0];
            MK_CORNER: r_mix[r_widx]   <= MW'(r_glo) + MW'(p_sh);
            MK_YLERP: begin
                if (r_widx[0]) begin
                    r_y1 <= r_mix[2] + MW'(p_sh);
                end else begin
                    r_y0 <= r_mix[0] + MW'(p_sh);
                end
            end
            MK_ZLERP:  r_val <= r_y0 + MW'(p_sh);
            default: ;
        endcase
    end

    // Configuration registers and reuse-cache tags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off[0]   <= '0;
            r_off[1]   <= '0;
            r_off[2]   <= '0;
            r_scale[0] <= 32'sd65536;
            r_scale[1] <= 32'sd65536;
            r_scale[2] <= 32'sd65536;
            r_inv      <= 32'd65536;
            r_ccy      <= 8'd0;
            r_cvalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFF_X:   r_off[0]   <= i_cfg_data;
                    CFG_OFF_Y:   r_off[1]   <= i_cfg_data;
                    CFG_OFF_Z:   r_off[2]   <= i_cfg_data;
                    CFG_SCALE_X: r_scale[0] <= i_cfg_data[31:0];
                    CFG_SCALE_Y: r_scale[1] <= i_cfg_data[31:0];
                    CFG_SCALE_Z: r_scale[2] <= i_cfg_data[31:0];
                    CFG_INV_AMP: r_inv      <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_cmd.cache_upd) begin
                r_ccy    <= r_cell[1];
                r_cvalid <= 1'b1;
            end
        end
    end

    assign o_status.miss = r_col | ~r_cvalid | (r_cell[1] != r_ccy);

    // Final scaling and saturation straight from the product register.
    assign sum = SW'(r_acc) + SW'(p_sh);
    always_comb begin
        if (sum > SAT_HI) begin
            sat = 32'sh7FFF_FFFF;
        end else if (sum < SAT_LO) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= sat;
        end
    end

    assign o_status.out_full = r_ovalid & ~i_ready;
    assign o_valid           = r_ovalid;
    assign o_acc_out         = r_out;

endmodule

// ===== src/perlin_noise_3d_accumulate.sv =====
`timescale 1ns / 1ps
// Load word: written to the permutation memory in its accept cycle; one load word per cycle.
// Sample word: o_valid rises sooner when the cached corner mixes are reused than when they are
// rebuilt (14 permutation reads on one memory port, then the corner lerps).
// The next word is taken only after a sample's result is loaded for output, later while the output word waits.
// One shared multiplier is stepped through scaling, fade, lerps and gain; one sample at a time.
// Synchronous active-low reset clears the controller, output valid, cache tag and configuration registers.
module perlin_noise_3d_accumulate #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_op,
    input  logic [7:0]                     i_table_index,
    input  logic [7:0]                     i_table_value,
    input  logic signed [23:0]             i_pos_x,
    input  logic signed [23:0]             i_pos_y,
    input  logic signed [23:0]             i_pos_z,
    input  logic                           i_column_start,
    input  logic signed [31:0]             i_acc_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [31:0]             o_acc_out,
    input  logic                           i_cfg_we,
    input  logic [pn3d_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pn3d_pkg::CFG_DW-1:0]    i_cfg_data
);
    import pn3d_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    pn3d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pn3d_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_column_start (i_column_start),
        .i_acc_in       (i_acc_in),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_acc_out      (o_acc_out)
    );

endmodule

// ===== sim/pn3d_checker.sv =====
`timescale 1ns / 1ps
module pn3d_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_op,
    input  logic [7:0]                     i_table_index,
    input  logic [7:0]                     i_table_value,
    input  logic signed [23:0]             i_pos_x,
    input  logic signed [23:0]             i_pos_y,
    input  logic signed [23:0]             i_pos_z,
    input  logic                           i_column_start,
    input  logic signed [31:0]             i_acc_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic signed [31:0]             i_acc_out,
    input  logic                           i_cfg_we,
    input  logic [pn3d_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pn3d_pkg::CFG_DW-1:0]    i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import pn3d_pkg::*;

    localparam int     FB  = 16;
    localparam longint ONE = longint'(1) << FB;

    logic [7:0]         perm [TABLE_ENTRIES];
    bit                 mix_valid;
    logic [7:0]         mix_cell_y;
    logic signed [31:0] corner_mix [4];
    longint             origin [3];
    longint             gain [3];
    longint             inv_amp;
    logic signed [31:0] acc_expect_q [$];
    int                 errors;
    int                 sample_count;

    assign o_errors  = errors;
    assign o_pending = acc_expect_q.size();

    task automatic report_miss(input string what);
        $display("ERROR: %s", what);
        errors++;
    endtask

    // Arithmetic shift right is a floor division by a power of two.
    function automatic longint fade(input longint t);
        longint inner, t2, t3;
        inner = ((t * (6 * t - 15 * ONE)) >>> FB) + 10 * ONE;
        t2 = (t * t) >>> FB;
        t3 = (t2 * t) >>> FB;
        return (t3 * inner) >>> FB;
    endfunction

    function automatic longint lerp(input longint t, input longint a, input longint b);
        return a + ((t * (b - a)) >>> FB);
    endfunction

    function automatic longint grad(input logic [7:0] hash, input longint x,
                                    input longint y, input longint z);
        logic [3:0] h;
        longint a, b;
        h = hash[3:0];
        a = (h < 8) ? x : y;
        b = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        if (h[0]) a = -a;
        if (h[1]) b = -b;
        return a + b;
    endfunction

    function automatic logic [7:0] pt(input longint i);
        logic [7:0] k;
        k = i[7:0];
        return perm[k];
    endfunction

    function automatic logic signed [31:0] accumulate_noise(
        input logic signed [23:0] px, input logic signed [23:0] py,
        input logic signed [23:0] pz, input logic col, input logic signed [31:0] acc);
        longint cx, cy, cz, fx0, fy0, fz0, fx1, fy1, fz1, u, v, w;
        longint a, b, aa, ab, ba, bb, y0, y1, val, sum;
        longint coord [3];
        coord[0] = origin[0] + longint'(px) * gain[0];
        coord[1] = origin[1] + longint'(py) * gain[1];
        coord[2] = origin[2] + longint'(pz) * gain[2];
        cx = longint'(coord[0][23:16]);
        cy = longint'(coord[1][23:16]);
        cz = longint'(coord[2][23:16]);
        fx0 = longint'(coord[0][15:0]);
        fy0 = longint'(coord[1][15:0]);
        fz0 = longint'(coord[2][15:0]);
        fx1 = fx0 - ONE;
        fy1 = fy0 - ONE;
        fz1 = fz0 - ONE;
        u = fade(fx0);
        v = fade(fy0);
        w = fade(fz0);
        // The corner mixes survive y steps within one cell, even when x or z moved.
        if (col || !mix_valid || cy[7:0] != mix_cell_y) begin
            a  = longint'(pt(cx)) + cy;
            b  = longint'(pt(cx + 1)) + cy;
            aa = longint'(pt(a)) + cz;
            ab = longint'(pt(a + 1)) + cz;
            ba = longint'(pt(b)) + cz;
            bb = longint'(pt(b + 1)) + cz;
            corner_mix[0] = 32'(lerp(u, grad(pt(aa), fx0, fy0, fz0),
                                        grad(pt(ba), fx1, fy0, fz0)));
            corner_mix[1] = 32'(lerp(u, grad(pt(ab), fx0, fy1, fz0),
                                        grad(pt(bb), fx1, fy1, fz0)));
            corner_mix[2] = 32'(lerp(u, grad(pt(aa + 1), fx0, fy0, fz1),
                                        grad(pt(ba + 1), fx1, fy0, fz1)));
            corner_mix[3] = 32'(lerp(u, grad(pt(ab + 1), fx0, fy1, fz1),
                                        grad(pt(bb + 1), fx1, fy1, fz1)));
            mix_cell_y = cy[7:0];
            mix_valid  = 1'b1;
        end
        y0  = lerp(v, corner_mix[0], corner_mix[1]);
        y1  = lerp(v, corner_mix[2], corner_mix[3]);
        val = lerp(w, y0, y1);
        sum = longint'(acc) + ((val * inv_amp) >>> FB);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [31:0] want;
        if (!i_rst_n) begin
            mix_valid  = 1'b0;
            mix_cell_y = '0;
            for (int k = 0; k < 4; k++) corner_mix[k] = '0;
            for (int k = 0; k < 3; k++) begin
                origin[k] = 0;
                gain[k]   = 65536;
            end
            inv_amp = 65536;
            acc_expect_q.delete();
            sample_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFF_X:   origin[0] = longint'($signed(i_cfg_data[47:0]));
                    CFG_OFF_Y:   origin[1] = longint'($signed(i_cfg_data[47:0]));
                    CFG_OFF_Z:   origin[2] = longint'($signed(i_cfg_data[47:0]));
                    CFG_SCALE_X: gain[0] = longint'($signed(i_cfg_data[31:0]));
                    CFG_SCALE_Y: gain[1] = longint'($signed(i_cfg_data[31:0]));
                    CFG_SCALE_Z: gain[2] = longint'($signed(i_cfg_data[31:0]));
                    CFG_INV_AMP: inv_amp = longint'(i_cfg_data[31:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == OP_LOAD) begin
                    perm[i_table_index] = i_table_value;
                end else begin
                    acc_expect_q.push_back(accumulate_noise(i_pos_x, i_pos_y, i_pos_z,
                                                            i_column_start, i_acc_in));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (acc_expect_q.size() == 0) begin
                    report_miss($sformatf("unexpected word acc_out=%08h", i_acc_out));
                end else begin
                    want = acc_expect_q.pop_front();
                    if (i_acc_out !== want)
                        report_miss($sformatf("sample %0d acc_out=%08h expected %08h",
                                              sample_count, i_acc_out, want));
                    sample_count++;
                end
            end
        end
    end

    initial errors = 0;

endmodule

// ===== sim/tb_perlin_noise_3d_accumulate.sv =====
`timescale 1ns / 1ps
module tb_perlin_noise_3d_accumulate;
    import pn3d_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_op;
    logic [7:0]            i_table_index;
    logic [7:0]            i_table_value;
    logic signed [23:0]    i_pos_x;
    logic signed [23:0]    i_pos_y;
    logic signed [23:0]    i_pos_z;
    logic                  i_column_start;
    logic signed [31:0]    i_acc_in;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [31:0]    o_acc_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DW-1:0]     i_cfg_data;

    int   errors;
    int   pending;
    int   cycles;
    logic word_taken;
    bit   send_gaps;
    bit   recv_gaps;
    int   holdoff_left;

    logic signed [23:0] col_x, col_y, col_z;

    perlin_noise_3d_accumulate dut (.*);

    pn3d_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_op(i_op), .i_table_index(i_table_index), .i_table_value(i_table_value),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_column_start(i_column_start), .i_acc_in(i_acc_in),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_acc_out(o_acc_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        word_taken <= i_valid && o_ready;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The output side stalls at random, or for a long counted stretch on request.
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !recv_gaps || ($urandom_range(0, 99) >= 31);
        end
    end

    task automatic put_word(input logic op, input logic [7:0] ti, input logic [7:0] tv,
                            input logic [23:0] px, input logic [23:0] py,
                            input logic [23:0] pz, input logic col, input logic [31:0] acc);
        if (send_gaps && $urandom_range(0, 99) < 31) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_table_index  <= ti;
        i_table_value  <= tv;
        i_pos_x        <= px;
        i_pos_y        <= py;
        i_pos_z        <= pz;
        i_column_start <= col;
        i_acc_in       <= acc;
        do @(negedge i_clk); while (!word_taken);
    endtask

    task automatic put_sample(input logic [23:0] px, input logic [23:0] py,
                              input logic [23:0] pz, input logic col, input logic [31:0] acc);
        put_word(OP_SAMPLE, 8'($urandom), 8'($urandom), px, py, pz, col, acc);
    endtask

    // Loads are written in their accept cycle, so a short pause after the last result suffices.
    task automatic drain;
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [47:0] ox, input logic [47:0] oy,
                              input logic [47:0] oz, input logic [31:0] sx,
                              input logic [31:0] sy, input logic [31:0] sz,
                              input logic [31:0] amp);
        logic [47:0] vals [7];
        vals = '{ox, oy, oz, {{16{sx[31]}}, sx}, {{16{sy[31]}}, sy},
                 {{16{sz[31]}}, sz}, {16'h0, amp}};
        for (int k = 0; k < 7; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(k);
            i_cfg_data <= vals[k];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_acc();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 2047) - 1024;
            default: return $urandom;
        endcase
    endfunction

    // Most traffic walks down columns in y so the corner-mix reuse path is exercised.
    task automatic random_words(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                put_word(OP_LOAD, 8'($urandom), 8'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom), 1'($urandom), $urandom);
            end else if (r < 18) begin
                col_x = 24'($urandom_range(0, 600) - 300);
                col_y = 24'($urandom_range(0, 600) - 300);
                col_z = 24'($urandom_range(0, 600) - 300);
                put_sample(col_x, col_y, col_z, 1'b1, rand_acc());
            end else if (r < 80) begin
                col_y = col_y + 24'($urandom_range(0, 2));
                if ($urandom_range(0, 9) == 0) col_x = col_x + 24'sd1;
                put_sample(col_x, col_y, col_z, 1'b0, rand_acc());
            end else begin
                put_sample(24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom),
                           rand_acc());
            end
        end
    endtask

    initial begin
        logic [7:0] shuffle [256];
        logic [7:0] tmp;
        int         j;
        cycles         = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_op           = OP_LOAD;
        i_table_index  = '0;
        i_table_value  = '0;
        i_pos_x        = '0;
        i_pos_y        = '0;
        i_pos_z        = '0;
        i_column_start = 1'b0;
        i_acc_in       = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_OFF_X;
        i_cfg_data     = '0;
        send_gaps      = 1'b1;
        recv_gaps      = 1'b1;
        holdoff_left   = 0;
        col_x = '0;
        col_y = '0;
        col_z = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every table entry is written before the first sample can read it.
        for (int k = 0; k < 256; k++) shuffle[k] = k[7:0];
        for (int k = 255; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = shuffle[k];
            shuffle[k] = shuffle[j];
            shuffle[j] = tmp;
        end
        for (int k = 0; k < 256; k++)
            put_word(OP_LOAD, k[7:0], shuffle[k], 24'd0, 24'd0, 24'd0, 1'b0, 32'd0);

        // Directed samples at the field extremes and around the reuse cache.
        put_sample(24'd0, 24'd0, 24'd0, 1'b1, 32'd0);
        put_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 32'h7FFF_FFFF);
        put_sample(24'h800000, 24'h800000, 24'h800000, 1'b1, 32'h8000_0000);
        put_sample(24'd5, 24'd7, 24'd9, 1'b0, 32'h0001_0000);
        put_sample(24'd6, 24'd7, 24'd3, 1'b0, 32'hFFFF_0000);
        put_sample(24'd6, 24'd7, 24'd3, 1'b1, 32'hFFFF_0000);
        put_sample(24'd6, 24'd8, 24'd3, 1'b0, 32'd0);
        put_word(OP_LOAD, 8'hFF, 8'hFF, 24'd0, 24'd0, 24'd0, 1'b0, 32'd0);
        put_word(OP_LOAD, 8'h00, 8'h00, 24'd0, 24'd0, 24'd0, 1'b0, 32'd0);
        put_sample(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 32'h7FFF_FFFF);
        put_sample(24'd255, 24'd255, 24'd255, 1'b1, 32'h8000_0000);
        drain();

        write_regs(48'h0000_0003_8000, 48'hFFFF_FFFF_4000, 48'h0000_0000_1234,
                   32'h0001_8000, 32'h0000_2000, 32'hFFFF_0000, 32'h0002_0000);
        put_sample(24'd10, 24'd20, 24'd30, 1'b1, 32'd0);
        put_sample(24'd10, 24'd21, 24'd30, 1'b0, 32'd0);
        put_sample(24'd10, 24'd22, 24'd31, 1'b0, 32'd0);
        recv_gaps = 1'b0;
        send_gaps = 1'b0;
        random_words(200);
        recv_gaps = 1'b1;
        send_gaps = 1'b1;
        holdoff_left = 400;
        random_words(60);
        drain();

        write_regs(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'($urandom),
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        random_words(200);
        drain();

        write_regs(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h0,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000);
        random_words(200);
        drain();

        write_regs(48'({$urandom, $urandom}), 48'($urandom), 48'($urandom),
                   32'hFFFE_8000, 32'h0000_0800, $urandom, $urandom_range(0, 32'h0004_0000));
        random_words(200);
        drain();

        write_regs(48'($urandom), 48'($urandom), 48'($urandom), $urandom, 32'h0000_4000,
                   $urandom, 32'h0001_0000);
        random_words(200);
        drain();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
